FILE: hdl/per_source_score_threshold_blocker_macros.svh
// Assertion macros used by the per-source score threshold blocker engine.
`ifndef PER_SOURCE_SCORE_THRESHOLD_BLOCKER_MACROS_SVH
`define PER_SOURCE_SCORE_THRESHOLD_BLOCKER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define PSSB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define PSSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/pssb_pkg.sv
// Package with the sizes, status codes and result type of the score threshold blocker.
`default_nettype none
package pssb_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int SCORE_BITS = 16;
   localparam int IDX_BITS = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_BITS = SCORE_BITS + 1;
   localparam int THR_BITS = 16;
   localparam int CMP_BITS = (SCORE_BITS > THR_BITS) ? SCORE_BITS : THR_BITS;
   localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 16'd100;

   typedef enum logic [1:0] {
      STATUS_UPDATED = 2'd0,
      STATUS_CREATED = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] total_score;
      logic        block_now;
      logic [23:0] block_prefix;
   } result_type;

endpackage
`default_nettype wire

FILE: hdl/pssb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none
module pssb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/pssb_engine.sv
// Search and update engine: scans the source table, then updates the matched or new entry.
`default_nettype none
`include "per_source_score_threshold_blocker_macros.svh"
module pssb_engine
   import pssb_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [31:0]         req_ip,
   input  wire logic [7:0]          req_weight,
   input  wire logic [THR_BITS-1:0] threshold,
   output      logic                res_valid,
   output      result_type          res,
   input  wire logic                res_take
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   used_ff, used_in;
   logic [CNT_BITS-1:0]   issue_ff, issue_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [31:0]           ip_ff, ip_in;
   logic [7:0]            weight_ff, weight_in;
   logic [IDX_BITS-1:0]   slot_ff, slot_in;
   logic [SCORE_BITS-1:0] score_ff, score_in;
   logic                  blocked_ff, blocked_in;
   logic                  is_new_ff, is_new_in;
   result_type            result_ff, result_in;

   logic                  rd_en;
   logic [31:0]           addr_rd;
   logic [ENTRY_BITS-1:0] entry_rd;
   logic                  addr_wr_en;
   logic                  entry_wr_en;
   logic [ENTRY_BITS-1:0] entry_wr_data;

   logic                  hit;
   logic [SCORE_BITS:0]   sum_wide;
   logic [SCORE_BITS-1:0] sum;
   logic [CMP_BITS-1:0]   sum_ext;
   logic                  block;

   pssb_ram #(
      .WIDTH(32),
      .DEPTH(TABLE_DEPTH)
   ) u_addr_ram (
      .clock  (clock),
      .wr_en  (addr_wr_en),
      .wr_addr(slot_ff),
      .wr_data(ip_ff),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[IDX_BITS-1:0]),
      .rd_data(addr_rd)
   );

   // Each entry holds the blocked flag above the score.
   pssb_ram #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (entry_wr_en),
      .wr_addr(slot_ff),
      .wr_data(entry_wr_data),
      .rd_en  (rd_en),
      .rd_addr(issue_ff[IDX_BITS-1:0]),
      .rd_data(entry_rd)
   );

   assign sum_wide = {1'b0, score_ff} + (SCORE_BITS + 1)'(weight_ff);
   assign sum      = sum_wide[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum_wide[SCORE_BITS-1:0];
   assign sum_ext  = CMP_BITS'(sum);
   assign block    = !blocked_ff && (sum_ext >= CMP_BITS'(threshold));
   assign hit      = cmp_valid_ff && (addr_rd == ip_ff);

   assign entry_wr_data = {blocked_ff | block, sum};

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      issue_in     = issue_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      ip_in        = ip_ff;
      weight_in    = weight_ff;
      slot_in      = slot_ff;
      score_in     = score_ff;
      blocked_in   = blocked_ff;
      is_new_in    = is_new_ff;
      result_in    = result_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      rd_en        = 1'b0;
      addr_wr_en   = 1'b0;
      entry_wr_en  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ip_in        = req_ip;
               weight_in    = req_weight;
               issue_in     = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Reads are issued one entry per cycle; each compare follows in the cycle after its read.
            rd_en        = (issue_ff < used_ff);
            cmp_valid_in = rd_en;
            cmp_idx_in   = issue_ff[IDX_BITS-1:0];
            if (rd_en) begin
               issue_in = issue_ff + CNT_BITS'(1);
            end
            if (hit) begin
               slot_in      = cmp_idx_ff;
               score_in     = entry_rd[SCORE_BITS-1:0];
               blocked_in   = entry_rd[SCORE_BITS];
               is_new_in    = 1'b0;
               cmp_valid_in = 1'b0;
               state_in     = ST_UPDATE;
            end else if (!cmp_valid_ff && (issue_ff >= used_ff)) begin
               if (used_ff == CNT_BITS'(TABLE_DEPTH)) begin
                  result_in.status       = STATUS_FULL;
                  result_in.total_score  = '0;
                  result_in.block_now    = 1'b0;
                  result_in.block_prefix = '0;
                  state_in               = ST_DONE;
               end else begin
                  slot_in    = used_ff[IDX_BITS-1:0];
                  score_in   = '0;
                  blocked_in = 1'b0;
                  is_new_in  = 1'b1;
                  state_in   = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            entry_wr_en            = 1'b1;
            addr_wr_en             = is_new_ff;
            used_in                = used_ff + CNT_BITS'(is_new_ff);
            result_in.status       = is_new_ff ? STATUS_CREATED : STATUS_UPDATED;
            result_in.total_score  = sum_ext[15:0];
            result_in.block_now    = block;
            result_in.block_prefix = block ? ip_ff[31:8] : 24'd0;
            state_in               = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cmp_valid_ff <= cmp_valid_in;
      end
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      ip_ff      <= ip_in;
      weight_ff  <= weight_in;
      slot_ff    <= slot_in;
      score_ff   <= score_in;
      blocked_ff <= blocked_in;
      is_new_ff  <= is_new_in;
      result_ff  <= result_in;
   end

   assign res = result_ff;

   `PSSB_ASSERT_NOW(a_used_bound, 1'b1, used_ff <= CNT_BITS'(TABLE_DEPTH),
      "entry count exceeds table depth")
   `PSSB_ASSERT_NOW(a_full_only_when_full,
      (state_ff == ST_DONE) && (result_ff.status == STATUS_FULL),
      used_ff == CNT_BITS'(TABLE_DEPTH), "drop reported while table has room")
   `PSSB_ASSERT_NOW(a_block_prefix,
      (state_ff == ST_DONE) && result_ff.block_now,
      result_ff.block_prefix == ip_ff[31:8], "block prefix does not match source")
   `PSSB_ASSERT_NEXT(a_accept_starts_scan, req_valid && req_ready,
      (state_ff == ST_SCAN) && !cmp_valid_ff, "accepted word did not start a scan")

endmodule
`default_nettype wire

FILE: hdl/per_source_score_threshold_blocker.sv
// Per-source score threshold blocker: stream ports, threshold register and result register.
//
// Each request word carries an IPv4 source address and a score weight. The block looks the
// address up in a table of up to 1024 sources, appending it when absent, adds the weight to
// the source's saturating score and returns one response word per request: the status
// (updated, created, or dropped because the table is full), the new score, and a block order
// with the /24 prefix when the score first reaches the threshold. The lookup is a linear scan
// of the address memory, one stored entry per cycle, and a hit ends the scan early.
// Responses go through an output register, so a new request is taken while the previous
// response still waits.
`default_nettype none
module per_source_score_threshold_blocker
   import pssb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: src_ip [31:0], event_score [39:32]
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,
   // rsp_tdata: total_score [15:0], block_now [16], block_prefix [40:17], zero [47:41]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [47:0] rsp_tdata,
   // rsp_tuser: status [1:0]
   output      logic [1:0]  rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   logic [THR_BITS-1:0] threshold_ff, threshold_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_data_ff, rsp_data_in;

   logic                res_valid;
   result_type          res;
   logic                res_take;
   logic                csr_sel_thr;

   pssb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_ip    (req_tdata[31:0]),
      .req_weight(req_tdata[39:32]),
      .threshold (threshold_ff),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // The only register sits at byte address zero; bit 2 selects past it.
   assign csr_sel_thr = !csr_paddr[2];
   assign csr_pready  = 1'b1;
   assign csr_prdata  = csr_sel_thr ? {16'd0, threshold_ff} : 32'd0;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_thr) begin
         threshold_in = csr_pwdata[THR_BITS-1:0];
      end
   end

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {7'd0, rsp_data_ff.block_prefix, rsp_data_ff.block_now,
                        rsp_data_ff.total_score};

endmodule
`default_nettype wire
